@@ rtl/core/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants, reject codes and bus layout for the ray/triangle core.
// ----------------------------------------------------------------------------
package rti_pkg;

    // default component width of one packed coordinate
    localparam int COORD_WIDTH_DEF = 21;

    // fixed field widths
    localparam int FIELD_W = 63;
    localparam int T_W     = 32;
    localparam int BARY_W  = 16;
    localparam int T_FRAC  = 16;
    // quotient bits of t, one above the 32-bit result for saturation
    localparam int Q_W     = 33;

    // input tdata layout, lowest field first
    localparam int ORG_LSB  = 0;
    localparam int DIR_LSB  = ORG_LSB + FIELD_W;
    localparam int TMIN_LSB = DIR_LSB + FIELD_W;
    localparam int TMAX_LSB = TMIN_LSB + T_W;
    localparam int VA_LSB   = TMAX_LSB + T_W;
    localparam int VB_LSB   = VA_LSB + FIELD_W;
    localparam int VC_LSB   = VB_LSB + FIELD_W;
    localparam int IN_TDATA_W = 384;

    // output layout
    localparam int OUT_TDATA_W = 128;
    localparam int OUT_TUSER_W = 4;

    // reject codes
    typedef enum logic [2:0] {
        RSN_HIT      = 3'd0,
        RSN_PARALLEL = 3'd1,
        RSN_ALPHA    = 3'd2,
        RSN_BETA     = 3'd3,
        RSN_SUM      = 3'd4,
        RSN_RANGE    = 3'd5
    } reason_t;

    // ray fields carried alongside the arithmetic
    typedef struct packed {
        logic [FIELD_W-1:0] org;
        logic [FIELD_W-1:0] dir;
        logic [T_W-1:0]     tmin;
        logic [T_W-1:0]     tmax;
    } carry_t;

    // one result beat
    typedef struct packed {
        logic [OUT_TUSER_W-1:0] user;
        logic [OUT_TDATA_W-1:0] data;
    } beat_t;

endpackage

@@ rtl/core/rti_div_step.sv @@
// ----------------------------------------------------------------------------
// rti_div_step
// One registered restoring-division step: resolves a single quotient bit.
// ----------------------------------------------------------------------------
module rti_div_step #(
    parameter int RW    = 8,
    parameter int DEN_W = 4,
    parameter int QW    = 4,
    parameter int BIT   = 0
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [RW-1:0]    rem_i,
    input  logic [DEN_W-1:0] den_i,
    input  logic [QW-1:0]    q_i,
    output logic [RW-1:0]    rem_o,
    output logic [QW-1:0]    q_o
);

    logic [RW-1:0] trial;
    logic          ge;
    logic [RW-1:0] rem_next;
    logic [QW-1:0] q_next;
    logic [RW-1:0] rem_reg;
    logic [QW-1:0] q_reg;

    // compare against the shifted divisor and subtract on success
    always_comb begin
        trial    = RW'(den_i) << BIT;
        ge       = (rem_i >= trial);
        rem_next = ge ? (rem_i - trial) : rem_i;
        q_next   = q_i;
        q_next[BIT] = ge;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign rem_o = rem_reg;
    assign q_o   = q_reg;

endmodule

@@ rtl/core/ray_triangle_intersect_core.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core
// Ray/triangle hit test by Cramer's rule, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: origin, direction, t_min, t_max,
//          |     |                    |          vertex_a, vertex_b, vertex_c
//  m_      | out | m_tvalid/m_tready  | m_tdata: hit_distance, bary_alpha,
//          |     |                    |          bary_beta, hit_point
//          |     |                    | m_tuser: hit, reject_reason
//
//  one request per cycle while the skid register is empty
//  the depth is set by the 33-step t divider, one quotient bit per stage
//  reset (aresetn low, synchronous) empties the pipe and the output buffer
//  a stalled output parks in a skid register; input stalls only when it is full
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // origin[62:0], direction[125:63], t_min[157:126], t_max[189:158],
    // vertex_a[252:190], vertex_b[315:253], vertex_c[378:316], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // hit_distance[31:0], bary_alpha[47:32], bary_beta[63:48],
    // hit_point[126:64], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // hit[0], reject_reason[3:1]
    output logic [OUT_TUSER_W-1:0] m_tuser
);

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;
    localparam int CRW   = 2 * DW + 1;
    localparam int LO_W  = CRW / 2;
    localparam int HI_W  = CRW - LO_W;
    localparam int PH_W  = DW + HI_W;
    localparam int PL_W  = DW + LO_W + 1;
    localparam int PW    = 3 * DW + 3;
    localparam int RW_T  = PW + Q_W;
    localparam int RW_AB = PW + T_FRAC;
    localparam int AB_DLY = Q_W - BARY_W + 1;
    localparam int PR_W  = T_W + CW;
    localparam int PT_W  = PR_W - T_FRAC + 1;
    localparam int NSTG  = 8 + Q_W + 3;

    localparam logic [Q_W-1:0] Q_POS_LIM = Q_W'((64'd1 << (T_W - 1)) - 64'd1);
    localparam logic [Q_W-1:0] Q_NEG_LIM = Q_W'(64'd1 << (T_W - 1));
    localparam logic signed [T_W-1:0]  T_MIN = {1'b1, {(T_W-1){1'b0}}};
    localparam logic signed [T_W-1:0]  T_MAX = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [PT_W-1:0] P_HI  = PT_W'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [PT_W-1:0] P_LO  = -P_HI - PT_W'(1);
    localparam logic signed [PR_W-1:0] RND   = PR_W'((64'd1 << T_FRAC) - 64'd1);

    // pipeline control
    logic              en;
    logic [NSTG-1:0]   vld_reg;
    carry_t            cry_reg [0:NSTG-2];

    // stage 1: edges and offset
    logic signed [CW-1:0] in_o [3];
    logic signed [CW-1:0] in_d [3];
    logic signed [CW-1:0] in_a [3];
    logic signed [CW-1:0] in_b [3];
    logic signed [CW-1:0] in_c [3];
    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];
    logic signed [DW-1:0] s1_reg [3];
    logic signed [DW-1:0] nd1_reg [3];

    // stage 2: cross products
    logic signed [2*DW-1:0] pn_a [3];
    logic signed [2*DW-1:0] pn_b [3];
    logic signed [2*DW-1:0] p1_a [3];
    logic signed [2*DW-1:0] p1_b [3];
    logic signed [2*DW-1:0] p2_a [3];
    logic signed [2*DW-1:0] p2_b [3];
    logic signed [CRW-1:0]  n_reg [3];
    logic signed [CRW-1:0]  m1_reg [3];
    logic signed [CRW-1:0]  m2_reg [3];
    logic signed [DW-1:0]   s2_reg [3];
    logic signed [DW-1:0]   nd2_reg [3];

    // stage 3..5: dot products
    logic signed [DW-1:0]   du [4][3];
    logic signed [CRW-1:0]  dv [4][3];
    logic signed [PH_W-1:0] ph_c [4][3];
    logic signed [PL_W-1:0] pl_c [4][3];
    logic signed [PH_W-1:0] ph_reg [4][3];
    logic signed [PL_W-1:0] pl_reg [4][3];
    logic signed [PW-1:0]   term_reg [4][3];
    logic signed [PW-1:0]   dot_reg [4];

    // stage 6..8: sign fix, tests, divider setup
    logic            dz6_reg;
    logic [PW-1:0]   det6_reg, an6_reg, bn6_reg, tn6_reg;
    logic            neg5;
    logic            an_bad, bn_bad, sum_bad;
    reason_t         rsn7_c;
    reason_t         rsn7_reg;
    logic            tneg7_reg;
    logic [PW-1:0]   tmag7_reg, det7_reg, an7_reg, bn7_reg;

    // divider chain
    logic [PW-1:0]    det_p_reg  [0:Q_W];
    reason_t          rsn_p_reg  [0:Q_W];
    logic             tneg_p_reg [0:Q_W];
    logic             tsat_p_reg [0:Q_W];
    logic [RW_T-1:0]  t_rem0_reg;
    logic [RW_T-1:0]  t_rem [0:Q_W];
    logic [Q_W-1:0]   tq [0:Q_W];
    logic [RW_AB-1:0] a_dly_reg [0:AB_DLY-1];
    logic [RW_AB-1:0] b_dly_reg [0:AB_DLY-1];
    logic [RW_AB-1:0] a_rem [0:BARY_W];
    logic [RW_AB-1:0] b_rem [0:BARY_W];
    logic [BARY_W-1:0] aq [0:BARY_W];
    logic [BARY_W-1:0] bq [0:BARY_W];

    // tail: t, hit point, result
    logic [Q_W-1:0]        q_fin;
    logic signed [T_W-1:0] t_c;
    logic signed [T_W-1:0] t1_reg;
    reason_t               rsn1_reg, rsn2_reg;
    logic [BARY_W-1:0]     al1_reg, be1_reg, al2_reg, be2_reg;
    logic signed [T_W-1:0] t2_reg;
    logic signed [CW-1:0]  d_t2 [3];
    logic signed [PR_W-1:0] prod2_reg [3];
    logic signed [CW-1:0]  o_t3 [3];
    logic signed [PR_W-1:0] adj;
    logic signed [PT_W-1:0] p_c;
    logic [FIELD_W-1:0]    pt_c;
    beat_t                 beat_c, beat3_reg;

    // output buffer
    logic  out_vld_reg, skid_vld_reg;
    beat_t out_beat_reg, skid_beat_reg;

    // the pipe moves whenever the skid register is free
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // ray fields travel with the item
    always_ff @(posedge aclk) begin
        if (en) begin
            cry_reg[0].org  <= s_tdata[ORG_LSB +: FIELD_W];
            cry_reg[0].dir  <= s_tdata[DIR_LSB +: FIELD_W];
            cry_reg[0].tmin <= s_tdata[TMIN_LSB +: T_W];
            cry_reg[0].tmax <= s_tdata[TMAX_LSB +: T_W];
            for (int i = 1; i < NSTG - 1; i++) begin
                cry_reg[i] <= cry_reg[i-1];
            end
        end
    end

    // stage 1: unpack and difference
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_o[k] = $signed(s_tdata[ORG_LSB + k*CW +: CW]);
            in_d[k] = $signed(s_tdata[DIR_LSB + k*CW +: CW]);
            in_a[k] = $signed(s_tdata[VA_LSB + k*CW +: CW]);
            in_b[k] = $signed(s_tdata[VB_LSB + k*CW +: CW]);
            in_c[k] = $signed(s_tdata[VC_LSB + k*CW +: CW]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                e1_reg[k]  <= DW'(in_b[k]) - DW'(in_a[k]);
                e2_reg[k]  <= DW'(in_c[k]) - DW'(in_a[k]);
                s1_reg[k]  <= DW'(in_o[k]) - DW'(in_a[k]);
                nd1_reg[k] <= -DW'(in_d[k]);
            end
        end
    end

    // stage 2: n = e1 x e2, m1 = s x e2, m2 = e1 x s
    always_comb begin
        int k1;
        int k2;
        for (int k = 0; k < 3; k++) begin
            k1 = (k + 1) % 3;
            k2 = (k + 2) % 3;
            pn_a[k] = e1_reg[k1] * e2_reg[k2];
            pn_b[k] = e1_reg[k2] * e2_reg[k1];
            p1_a[k] = s1_reg[k1] * e2_reg[k2];
            p1_b[k] = s1_reg[k2] * e2_reg[k1];
            p2_a[k] = e1_reg[k1] * s1_reg[k2];
            p2_b[k] = e1_reg[k2] * s1_reg[k1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                n_reg[k]   <= CRW'(pn_a[k]) - CRW'(pn_b[k]);
                m1_reg[k]  <= CRW'(p1_a[k]) - CRW'(p1_b[k]);
                m2_reg[k]  <= CRW'(p2_a[k]) - CRW'(p2_b[k]);
                s2_reg[k]  <= s1_reg[k];
                nd2_reg[k] <= nd1_reg[k];
            end
        end
    end

    // stage 3: dot partial products, cross operand split in high and low halves
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            du[0][k] = nd2_reg[k];
            dv[0][k] = n_reg[k];
            du[1][k] = nd2_reg[k];
            dv[1][k] = m1_reg[k];
            du[2][k] = nd2_reg[k];
            dv[2][k] = m2_reg[k];
            du[3][k] = s2_reg[k];
            dv[3][k] = n_reg[k];
        end
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 3; k++) begin
                ph_c[i][k] = du[i][k] * $signed(dv[i][k][CRW-1:LO_W]);
                pl_c[i][k] = du[i][k] * $signed({1'b0, dv[i][k][LO_W-1:0]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg <= ph_c;
            pl_reg <= pl_c;
        end
    end

    // stage 4: recombine halves; stage 5: sum the three terms
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 3; k++) begin
                    term_reg[i][k] <= (PW'(ph_reg[i][k]) <<< LO_W) + PW'(pl_reg[i][k]);
                end
                dot_reg[i] <= term_reg[i][0] + term_reg[i][1] + term_reg[i][2];
            end
        end
    end

    // stage 6: make det positive
    assign neg5 = dot_reg[0][PW-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            dz6_reg  <= (dot_reg[0] == '0);
            det6_reg <= neg5 ? -dot_reg[0] : dot_reg[0];
            an6_reg  <= neg5 ? -dot_reg[1] : dot_reg[1];
            bn6_reg  <= neg5 ? -dot_reg[2] : dot_reg[2];
            tn6_reg  <= neg5 ? -dot_reg[3] : dot_reg[3];
        end
    end

    // stage 7: barycentric tests and |t numerator|
    always_comb begin
        an_bad  = an6_reg[PW-1] || (an6_reg == '0) || (an6_reg >= det6_reg);
        bn_bad  = bn6_reg[PW-1] || (bn6_reg == '0) || (bn6_reg >= det6_reg);
        sum_bad = ({1'b0, an6_reg} + {1'b0, bn6_reg}) >= {1'b0, det6_reg};
        if (dz6_reg) begin
            rsn7_c = RSN_PARALLEL;
        end else if (an_bad) begin
            rsn7_c = RSN_ALPHA;
        end else if (bn_bad) begin
            rsn7_c = RSN_BETA;
        end else if (sum_bad) begin
            rsn7_c = RSN_SUM;
        end else begin
            rsn7_c = RSN_HIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rsn7_reg  <= rsn7_c;
            tneg7_reg <= tn6_reg[PW-1];
            tmag7_reg <= tn6_reg[PW-1] ? -tn6_reg : tn6_reg;
            det7_reg  <= det6_reg;
            an7_reg   <= an6_reg;
            bn7_reg   <= bn6_reg;
        end
    end

    // stage 8: divider setup and t overflow check; then side fields follow the divider
    always_ff @(posedge aclk) begin
        if (en) begin
            t_rem0_reg    <= RW_T'(tmag7_reg) << T_FRAC;
            det_p_reg[0]  <= det7_reg;
            rsn_p_reg[0]  <= rsn7_reg;
            tneg_p_reg[0] <= tneg7_reg;
            tsat_p_reg[0] <= {{(T_FRAC+1){1'b0}}, tmag7_reg} >=
                             {det7_reg, {(T_FRAC+1){1'b0}}};
            a_dly_reg[0]  <= RW_AB'(an7_reg) << T_FRAC;
            b_dly_reg[0]  <= RW_AB'(bn7_reg) << T_FRAC;
            for (int j = 1; j <= Q_W; j++) begin
                det_p_reg[j]  <= det_p_reg[j-1];
                rsn_p_reg[j]  <= rsn_p_reg[j-1];
                tneg_p_reg[j] <= tneg_p_reg[j-1];
                tsat_p_reg[j] <= tsat_p_reg[j-1];
            end
            for (int j = 1; j < AB_DLY; j++) begin
                a_dly_reg[j] <= a_dly_reg[j-1];
                b_dly_reg[j] <= b_dly_reg[j-1];
            end
        end
    end

    assign t_rem[0] = t_rem0_reg;
    assign tq[0]    = '0;
    assign a_rem[0] = a_dly_reg[AB_DLY-1];
    assign b_rem[0] = b_dly_reg[AB_DLY-1];
    assign aq[0]    = '0;
    assign bq[0]    = '0;

    // t divider: one quotient bit per stage, high bit first
    for (genvar j = 0; j < Q_W; j++) begin : g_tdiv
        rti_div_step #(
            .RW    (RW_T),
            .DEN_W (PW),
            .QW    (Q_W),
            .BIT   (Q_W - 1 - j)
        ) u_tstep (
            .aclk  (aclk),
            .en    (en),
            .rem_i (t_rem[j]),
            .den_i (det_p_reg[j]),
            .q_i   (tq[j]),
            .rem_o (t_rem[j+1]),
            .q_o   (tq[j+1])
        );
    end

    // alpha and beta dividers run alongside the low t bits
    for (genvar m = 0; m < BARY_W; m++) begin : g_abdiv
        rti_div_step #(
            .RW    (RW_AB),
            .DEN_W (PW),
            .QW    (BARY_W),
            .BIT   (BARY_W - 1 - m)
        ) u_astep (
            .aclk  (aclk),
            .en    (en),
            .rem_i (a_rem[m]),
            .den_i (det_p_reg[Q_W - BARY_W + m]),
            .q_i   (aq[m]),
            .rem_o (a_rem[m+1]),
            .q_o   (aq[m+1])
        );
        rti_div_step #(
            .RW    (RW_AB),
            .DEN_W (PW),
            .QW    (BARY_W),
            .BIT   (BARY_W - 1 - m)
        ) u_bstep (
            .aclk  (aclk),
            .en    (en),
            .rem_i (b_rem[m]),
            .den_i (det_p_reg[Q_W - BARY_W + m]),
            .q_i   (bq[m]),
            .rem_o (b_rem[m+1]),
            .q_o   (bq[m+1])
        );
    end

    // tail stage 1: signed, saturated t and range test
    always_comb begin
        q_fin = tq[Q_W];
        if (tneg_p_reg[Q_W]) begin
            if (tsat_p_reg[Q_W] || (q_fin > Q_NEG_LIM)) begin
                t_c = T_MIN;
            end else begin
                t_c = -$signed(q_fin[T_W-1:0]);
            end
        end else begin
            if (tsat_p_reg[Q_W] || (q_fin > Q_POS_LIM)) begin
                t_c = T_MAX;
            end else begin
                t_c = $signed(q_fin[T_W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg  <= t_c;
            al1_reg <= aq[BARY_W];
            be1_reg <= bq[BARY_W];
            if ((rsn_p_reg[Q_W] == RSN_HIT) &&
                ((t_c < $signed(cry_reg[NSTG-4].tmin)) ||
                 (t_c > $signed(cry_reg[NSTG-4].tmax)))) begin
                rsn1_reg <= RSN_RANGE;
            end else begin
                rsn1_reg <= rsn_p_reg[Q_W];
            end
        end
    end

    // tail stage 2: t times direction
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_t2[k] = $signed(cry_reg[NSTG-3].dir[k*CW +: CW]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                prod2_reg[k] <= PR_W'(t1_reg) * PR_W'(d_t2[k]);
            end
            t2_reg   <= t1_reg;
            rsn2_reg <= rsn1_reg;
            al2_reg  <= al1_reg;
            be2_reg  <= be1_reg;
        end
    end

    // tail stage 3: truncate toward zero, add origin, clamp, pack result
    always_comb begin
        pt_c = '0;
        adj  = '0;
        p_c  = '0;
        for (int k = 0; k < 3; k++) begin
            o_t3[k] = $signed(cry_reg[NSTG-2].org[k*CW +: CW]);
            adj = prod2_reg[k][PR_W-1] ? (prod2_reg[k] + RND) : prod2_reg[k];
            p_c = PT_W'(o_t3[k]) + PT_W'(adj >>> T_FRAC);
            if (p_c > P_HI) begin
                p_c = P_HI;
            end else if (p_c < P_LO) begin
                p_c = P_LO;
            end
            pt_c[k*CW +: CW] = p_c[CW-1:0];
        end
        beat_c.user = {rsn2_reg, (rsn2_reg == RSN_HIT)};
        if (rsn2_reg == RSN_HIT) begin
            beat_c.data = {1'b0, pt_c, be2_reg, al2_reg, t2_reg};
        end else begin
            beat_c.data = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            beat3_reg <= beat_c;
        end
    end

    // output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (!out_vld_reg || m_tready) begin
                if (skid_vld_reg) begin
                    out_vld_reg  <= 1'b1;
                    out_beat_reg <= skid_beat_reg;
                    skid_vld_reg <= 1'b0;
                end else begin
                    out_vld_reg  <= vld_reg[NSTG-1];
                    out_beat_reg <= beat3_reg;
                end
            end else if (vld_reg[NSTG-1] && en) begin
                skid_vld_reg  <= 1'b1;
                skid_beat_reg <= beat3_reg;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_beat_reg.data;
    assign m_tuser  = out_beat_reg.user;

    // skid holds a result only behind a stalled output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry without output entry");

    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss with nonzero payload");

    // a held pipe keeps its occupancy
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> (vld_reg == $past(vld_reg)))
        else $error("pipe moved while stalled");

endmodule
